// ----- design/gha_pkg.sv -----
`default_nettype none
package gha_pkg;

   localparam int KEY_W = 64;
   localparam int VER_PORT_W = 32;

   typedef enum logic [1:0] {
      OP_CREATE,
      OP_REMOVE,
      OP_FIND,
      OP_CHECK
   } op_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_DUP,
      ST_MISS,
      ST_FULL
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_ALLOC,
      S_POP_WAIT,
      S_VER_WAIT,
      S_HANDLE,
      S_HWAIT
   } state_type;

   typedef enum logic [3:0] {
      FIN_NONE,
      FIN_DUP,
      FIN_FOUND,
      FIN_MISS,
      FIN_FULL,
      FIN_NEW,
      FIN_REUSE,
      FIN_REMOVE,
      FIN_CHECK
   } fin_type;

   typedef struct packed {
      logic    load;
      logic    scan;
      logic    pop;
      logic    rd_pop;
      logic    rd_handle;
      fin_type fin;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   hit;
      logic   scan_end;
      logic   stack_any;
      logic   slots_left;
      logic   handle_ok;
      logic   handle_live;
      logic   out_free;
   } stat_type;

endpackage
`default_nettype wire

// ----- design/gha_ctrl.sv -----
`default_nettype none
module gha_ctrl import gha_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [1:0] req_op,
   output logic            req_stall,
   input  wire stat_type   stat,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   op_type    new_op;

   assign new_op = op_type'(req_op);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (new_op == OP_CREATE || new_op == OP_FIND) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_HANDLE;
               end
            end
         end
         S_SCAN: begin
            if (stat.hit) begin
               if (stat.out_free) state_in = S_IDLE;
            end else if (stat.scan_end) begin
               if (stat.op == OP_FIND) begin
                  if (stat.out_free) state_in = S_IDLE;
               end else begin
                  state_in = S_ALLOC;
               end
            end
         end
         S_ALLOC: begin
            if (stat.stack_any) begin
               state_in = S_POP_WAIT;
            end else if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_POP_WAIT: begin
            state_in = S_VER_WAIT;
         end
         S_VER_WAIT: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         S_HANDLE: begin
            if (stat.handle_ok) begin
               state_in = S_HWAIT;
            end else if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_HWAIT: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      cmd.fin = FIN_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
         end
         S_SCAN: begin
            if (stat.hit) begin
               if (stat.out_free) begin
                  cmd.fin = (stat.op == OP_CREATE) ? FIN_DUP : FIN_FOUND;
               end
            end else if (stat.scan_end) begin
               if (stat.op == OP_FIND && stat.out_free) cmd.fin = FIN_MISS;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         S_ALLOC: begin
            if (stat.stack_any) begin
               cmd.pop = 1'b1;
            end else if (stat.out_free) begin
               cmd.fin = stat.slots_left ? FIN_NEW : FIN_FULL;
            end
         end
         S_POP_WAIT: begin
            cmd.rd_pop = 1'b1;
         end
         S_VER_WAIT: begin
            if (stat.out_free) cmd.fin = FIN_REUSE;
         end
         S_HANDLE: begin
            if (stat.handle_ok) begin
               cmd.rd_handle = 1'b1;
            end else if (stat.out_free) begin
               cmd.fin = FIN_MISS;
            end
         end
         S_HWAIT: begin
            if (stat.out_free) begin
               if (!stat.handle_live) begin
                  cmd.fin = FIN_MISS;
               end else if (stat.op == OP_REMOVE) begin
                  cmd.fin = FIN_REMOVE;
               end else begin
                  cmd.fin = FIN_CHECK;
               end
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- design/gha_datapath.sv -----
`default_nettype none
module gha_datapath import gha_pkg::*; #(
   parameter int MAX_SLOTS = 256,
   parameter int VERSION_BITS = 32,
   localparam int IDX_W = $clog2(MAX_SLOTS),
   localparam int CNT_W = $clog2(MAX_SLOTS + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [1:0]            req_op,
   input  wire logic [KEY_W-1:0]      req_uuid_hi,
   input  wire logic [KEY_W-1:0]      req_uuid_lo,
   input  wire logic [IDX_W-1:0]      req_entity_index,
   input  wire logic [VER_PORT_W-1:0] req_entity_version,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [IDX_W-1:0]           rsp_out_index,
   output logic [VER_PORT_W-1:0]      rsp_out_version,
   output logic [KEY_W-1:0]           rsp_key_hi,
   output logic [KEY_W-1:0]           rsp_key_lo,
   output logic [CNT_W-1:0]           rsp_live_count,
   input  wire cmd_type               cmd,
   output stat_type                   stat
);

   typedef struct packed {
      logic                    live;
      logic [VERSION_BITS-1:0] ver;
      logic [KEY_W-1:0]        khi;
      logic [KEY_W-1:0]        klo;
   } slot_type;

   slot_type slot_mem [MAX_SLOTS];
   logic [IDX_W-1:0] stack_mem [MAX_SLOTS];

   // latched item
   op_type                  op_ff;
   logic [KEY_W-1:0]        khi_ff, klo_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic [VER_PORT_W-1:0]   ver_ff;

   // table state
   logic [CNT_W-1:0] hw_ff, hw_in;
   logic [CNT_W-1:0] top_ff, top_in;
   logic [CNT_W-1:0] live_ff, live_in;

   // scan pipeline
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_slot_ff, pend_slot_in;
   logic             scan_more;

   // memory ports
   slot_type         rd_ff;
   logic [IDX_W-1:0] fs_rd_ff;
   logic [IDX_W-1:0] tgt_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   slot_type         wr_data;
   logic             push_en;
   logic [CNT_W-1:0] top_dec;
   logic [VERSION_BITS-1:0] ver_inc, ver_next;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff, status_in;
   logic [IDX_W-1:0]      oidx_ff, oidx_in;
   logic [VER_PORT_W-1:0] over_ff, over_in;
   logic [KEY_W-1:0]      ohi_ff, ohi_in, olo_ff, olo_in;
   logic [CNT_W-1:0]      ocnt_ff;

   assign scan_more = scan_ff < hw_ff;
   assign top_dec   = top_ff - 1'b1;
   assign ver_inc   = rd_ff.ver + 1'b1;
   assign ver_next  = (ver_inc == '0) ? VERSION_BITS'(1) : ver_inc;

   assign stat.op          = op_ff;
   assign stat.hit         = pend_ff && rd_ff.live && rd_ff.khi == khi_ff && rd_ff.klo == klo_ff;
   assign stat.scan_end    = !pend_ff && !scan_more;
   assign stat.stack_any   = top_ff != '0;
   assign stat.slots_left  = hw_ff < CNT_W'(MAX_SLOTS);
   assign stat.handle_ok   = ver_ff != '0 && (ver_ff >> VERSION_BITS) == '0
                             && CNT_W'(idx_ff) < hw_ff;
   assign stat.handle_live = rd_ff.live && rd_ff.ver == ver_ff[VERSION_BITS-1:0];
   assign stat.out_free    = !rsp_valid_ff || !rsp_stall;

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op_type'(req_op);
         khi_ff <= req_uuid_hi;
         klo_ff <= req_uuid_lo;
         idx_ff <= req_entity_index;
         ver_ff <= req_entity_version;
      end
   end

   // scan sequencing
   always_comb begin
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      if (cmd.load) begin
         scan_in = '0;
         pend_in = 1'b0;
      end else if (cmd.scan) begin
         pend_in      = scan_more;
         pend_slot_in = scan_ff[IDX_W-1:0];
         if (scan_more) scan_in = scan_ff + 1'b1;
      end
   end

   // slot memory read
   assign rd_en = (cmd.scan && scan_more) || cmd.rd_pop || cmd.rd_handle;

   always_comb begin
      priority if (cmd.rd_pop) begin
         rd_addr = fs_rd_ff;
      end else if (cmd.rd_handle) begin
         rd_addr = idx_ff;
      end else begin
         rd_addr = scan_ff[IDX_W-1:0];
      end
   end

   // table updates and result
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = tgt_ff;
      wr_data   = '0;
      push_en   = 1'b0;
      hw_in     = hw_ff;
      top_in    = cmd.pop ? top_dec : top_ff;
      live_in   = live_ff;
      status_in = ST_OK;
      oidx_in   = '0;
      over_in   = '0;
      ohi_in    = '0;
      olo_in    = '0;
      unique case (cmd.fin)
         FIN_DUP: begin
            status_in = ST_DUP;
         end
         FIN_FOUND: begin
            oidx_in = pend_slot_ff;
            over_in = VER_PORT_W'(rd_ff.ver);
         end
         FIN_MISS: begin
            status_in = ST_MISS;
         end
         FIN_FULL: begin
            status_in = ST_FULL;
         end
         FIN_NEW: begin
            wr_en   = 1'b1;
            wr_addr = hw_ff[IDX_W-1:0];
            wr_data = '{live: 1'b1, ver: VERSION_BITS'(1), khi: khi_ff, klo: klo_ff};
            hw_in   = hw_ff + 1'b1;
            live_in = live_ff + 1'b1;
            oidx_in = hw_ff[IDX_W-1:0];
            over_in = VER_PORT_W'(1);
         end
         FIN_REUSE: begin
            wr_en   = 1'b1;
            wr_addr = tgt_ff;
            wr_data = '{live: 1'b1, ver: ver_next, khi: khi_ff, klo: klo_ff};
            live_in = live_ff + 1'b1;
            oidx_in = tgt_ff;
            over_in = VER_PORT_W'(ver_next);
         end
         FIN_REMOVE: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = '{live: 1'b0, ver: rd_ff.ver, khi: '0, klo: '0};
            if (top_ff < CNT_W'(MAX_SLOTS)) begin
               push_en = 1'b1;
               top_in  = top_ff + 1'b1;
            end
            if (live_ff != '0) live_in = live_ff - 1'b1;
         end
         FIN_CHECK: begin
            ohi_in = rd_ff.khi;
            olo_in = rd_ff.klo;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cmd.fin != FIN_NONE) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff        <= '0;
         top_ff       <= '0;
         live_ff      <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hw_ff        <= hw_in;
         top_ff       <= top_in;
         live_ff      <= live_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_slot_ff <= pend_slot_in;
      if (cmd.rd_pop) tgt_ff <= fs_rd_ff;
      if (cmd.fin != FIN_NONE) begin
         status_ff <= status_in;
         oidx_ff   <= oidx_in;
         over_ff   <= over_in;
         ohi_ff    <= ohi_in;
         olo_ff    <= olo_in;
         ocnt_ff   <= live_in;
      end
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (rd_en) rd_ff <= slot_mem[rd_addr];
      if (wr_en) slot_mem[wr_addr] <= wr_data;
   end

   // free stack memory
   always_ff @(posedge clock) begin
      if (cmd.pop) fs_rd_ff <= stack_mem[top_dec[IDX_W-1:0]];
      if (push_en) stack_mem[top_ff[IDX_W-1:0]] <= idx_ff;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_index   = oidx_ff;
   assign rsp_out_version = over_ff;
   assign rsp_key_hi      = ohi_ff;
   assign rsp_key_lo      = olo_ff;
   assign rsp_live_count  = ocnt_ff;

endmodule
`default_nettype wire

// ----- design/generational_handle_allocator.sv -----
// operation: find scans the slots below the high-water mark, one slot per cycle through
//   the slot memory read port; create scans alike, then pops a freed slot from the free
//   stack and reads its version, or takes a new slot; remove and check read the handle's slot
// throughput: one item at a time; the next item is taken while the last result waits
// reset: synchronous; clears counts, free stack pointer and handshake state at once,
//   memories are not cleared and need no clearing pass
`default_nettype none
module generational_handle_allocator import gha_pkg::*; #(
   parameter int MAX_SLOTS = 256,
   parameter int VERSION_BITS = 32,
   localparam int IDX_W = $clog2(MAX_SLOTS),
   localparam int CNT_W = $clog2(MAX_SLOTS + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_op,
   input  wire logic [KEY_W-1:0]      req_uuid_hi,
   input  wire logic [KEY_W-1:0]      req_uuid_lo,
   input  wire logic [IDX_W-1:0]      req_entity_index,
   input  wire logic [VER_PORT_W-1:0] req_entity_version,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [IDX_W-1:0]           rsp_out_index,
   output logic [VER_PORT_W-1:0]      rsp_out_version,
   output logic [KEY_W-1:0]           rsp_key_hi,
   output logic [KEY_W-1:0]           rsp_key_lo,
   output logic [CNT_W-1:0]           rsp_live_count
);

   cmd_type  cmd;
   stat_type stat;

   gha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   gha_datapath #(
      .MAX_SLOTS    (MAX_SLOTS),
      .VERSION_BITS (VERSION_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_op             (req_op),
      .req_uuid_hi        (req_uuid_hi),
      .req_uuid_lo        (req_uuid_lo),
      .req_entity_index   (req_entity_index),
      .req_entity_version (req_entity_version),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_out_index      (rsp_out_index),
      .rsp_out_version    (rsp_out_version),
      .rsp_key_hi         (rsp_key_hi),
      .rsp_key_lo         (rsp_key_lo),
      .rsp_live_count     (rsp_live_count),
      .cmd                (cmd),
      .stat               (stat)
   );

endmodule
`default_nettype wire
